[hw/rtl/wrd_pkg.sv]
// ============================================================================
// wrd_pkg
// Shared constants, datapath operation codes and width helpers for the
// weighted RMS distance block.
// ============================================================================
package wrd_pkg;

    localparam int FRAC_BITS    = 16;
    localparam int VAL_W        = 17;
    localparam int MAX_DIMS_DEF = 64;
    localparam int PSQ_W        = 2 * FRAC_BITS + 1;
    localparam int IN_TDATA_W   = ((3 * VAL_W + 7) / 8) * 8;
    localparam int OUT_TDATA_W  = ((VAL_W + 7) / 8) * 8;

    localparam logic [VAL_W-1:0] ONE_VAL = VAL_W'(2 ** FRAC_BITS);

    localparam int OP_W = 4;
    localparam logic [OP_W-1:0] OP_NONE = 4'd0;
    localparam logic [OP_W-1:0] OP_ACC  = 4'd1;
    localparam logic [OP_W-1:0] OP_PSQ  = 4'd2;
    localparam logic [OP_W-1:0] OP_MUL  = 4'd3;
    localparam logic [OP_W-1:0] OP_MACC = 4'd4;
    localparam logic [OP_W-1:0] OP_DIVI = 4'd5;
    localparam logic [OP_W-1:0] OP_DIV  = 4'd6;
    localparam logic [OP_W-1:0] OP_SQI  = 4'd7;
    localparam logic [OP_W-1:0] OP_SQ   = 4'd8;
    localparam logic [OP_W-1:0] OP_OUT  = 4'd9;

    localparam int MUL_STEPS = 4;

    typedef struct packed {
        logic [OP_W-1:0] op;
        logic [1:0]      idx;
    } t_cmd;

    function automatic int f_cnt_w(int max_dims);
        return $clog2(max_dims + 1);
    endfunction

    function automatic int f_sum_w(int max_dims);
        return 2 * FRAC_BITS + f_cnt_w(max_dims);
    endfunction

    function automatic int f_q_w(int max_dims);
        return f_sum_w(max_dims) + 1;
    endfunction

    function automatic int f_rad_w(int max_dims);
        return f_q_w(max_dims) + (f_q_w(max_dims) % 2);
    endfunction

    function automatic int f_rt_w(int max_dims);
        return f_rad_w(max_dims) / 2;
    endfunction

endpackage

[hw/rtl/wrd_dp.sv]
// ============================================================================
// wrd_dp
// Datapath: squared-difference accumulator, split multiplier for potential
// squared times sum, restoring divider and restoring square root.
// ============================================================================
module wrd_dp #(
    parameter int MAX_DIMS = wrd_pkg::MAX_DIMS_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  wrd_pkg::t_cmd           i_cmd,
    input  logic [wrd_pkg::VAL_W-1:0] i_cond,
    input  logic [wrd_pkg::VAL_W-1:0] i_tol,
    input  logic [wrd_pkg::VAL_W-1:0] i_pot,
    output logic [wrd_pkg::VAL_W-1:0] o_sens
);
    import wrd_pkg::*;

    localparam int CNT_W  = f_cnt_w(MAX_DIMS);
    localparam int SUM_W  = f_sum_w(MAX_DIMS);
    localparam int P_W    = PSQ_W + SUM_W;
    localparam int Q_W    = f_q_w(MAX_DIMS);
    localparam int RAD_W  = f_rad_w(MAX_DIMS);
    localparam int RT_W   = f_rt_w(MAX_DIMS);
    localparam int SREM_W = RT_W + 2;
    localparam int AL     = (PSQ_W + 1) / 2;
    localparam int BL     = (SUM_W + 1) / 2;
    localparam int PP_W   = AL + BL;

    logic [VAL_W-1:0]   w_c_sat, w_t_sat, w_p_sat, w_diff;
    logic [2*VAL_W-1:0] w_sq;
    logic               w_room;

    logic [VAL_W-1:0]   r_diff, r_pot;
    logic               r_diff_vld;
    logic [CNT_W-1:0]   r_cnt;
    logic [SUM_W-1:0]   r_sum;

    logic [PSQ_W-1:0]   r_psq;
    logic [P_W-1:0]     r_pacc;
    logic [PP_W-1:0]    r_pp;
    logic [1:0]         r_pidx;
    logic               r_pp_vld;
    logic [AL-1:0]      w_a_sel;
    logic [BL-1:0]      w_b_sel;
    logic [PP_W-1:0]    w_pp;
    logic [P_W-1:0]     w_pp_sh;

    logic [Q_W-1:0]     r_quo;
    logic [CNT_W-1:0]   r_rem, r_dvs;
    logic [CNT_W:0]     w_dtrial, w_ddiff;
    logic               w_dge;

    logic [RAD_W-1:0]   r_rad;
    logic [RT_W-1:0]    r_root;
    logic [SREM_W-1:0]  r_srem;
    logic [SREM_W+1:0]  w_strial, w_ssub, w_sdiff;
    logic               w_sge;

    logic [VAL_W-1:0]   r_sens;

    assign w_c_sat = (i_cond > ONE_VAL) ? ONE_VAL : i_cond;
    assign w_t_sat = (i_tol  > ONE_VAL) ? ONE_VAL : i_tol;
    assign w_p_sat = (i_pot  > ONE_VAL) ? ONE_VAL : i_pot;
    assign w_diff  = (w_c_sat >= w_t_sat) ? (w_c_sat - w_t_sat) : (w_t_sat - w_c_sat);
    assign w_room  = (r_cnt < CNT_W'(MAX_DIMS));
    assign w_sq    = (2*VAL_W)'(r_diff) * (2*VAL_W)'(r_diff);

    // accumulator and element count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum      <= '0;
            r_cnt      <= '0;
            r_diff_vld <= 1'b0;
            r_pp_vld   <= 1'b0;
        end else begin
            r_diff_vld <= (i_cmd.op == OP_ACC) && w_room;
            if (r_diff_vld) begin
                r_sum <= r_sum + SUM_W'(w_sq);
            end
            if (i_cmd.op == OP_ACC && w_room) begin
                r_cnt <= r_cnt + CNT_W'(1);
            end
            if (i_cmd.op == OP_DIVI) begin
                r_sum <= '0;
                r_cnt <= '0;
            end
            if (i_cmd.op == OP_PSQ) begin
                r_pp_vld <= 1'b0;
            end else if (i_cmd.op == OP_MUL) begin
                r_pp_vld <= 1'b1;
            end
        end
    end

    // partial products of potential squared times sum
    always_comb begin
        w_a_sel = i_cmd.idx[0] ? AL'(r_psq[PSQ_W-1:AL]) : r_psq[AL-1:0];
        w_b_sel = i_cmd.idx[1] ? BL'(r_sum[SUM_W-1:BL]) : r_sum[BL-1:0];
        w_pp    = PP_W'(w_a_sel) * PP_W'(w_b_sel);
        case (r_pidx)
            2'd0:    w_pp_sh = P_W'(r_pp);
            2'd1:    w_pp_sh = P_W'(r_pp) << AL;
            2'd2:    w_pp_sh = P_W'(r_pp) << BL;
            default: w_pp_sh = P_W'(r_pp) << (AL + BL);
        endcase
    end

    // restoring divide step
    assign w_dtrial = {r_rem, r_quo[Q_W-1]};
    assign w_ddiff  = w_dtrial - {1'b0, r_dvs};
    assign w_dge    = (w_dtrial >= {1'b0, r_dvs});

    // restoring square root step
    assign w_strial = {r_srem, r_rad[RAD_W-1:RAD_W-2]};
    assign w_ssub   = (SREM_W+2)'({r_root, 2'b01});
    assign w_sdiff  = w_strial - w_ssub;
    assign w_sge    = (w_strial >= w_ssub);

    always_ff @(posedge i_clk) begin
        if (i_cmd.op == OP_ACC) begin
            r_diff <= w_diff;
            r_pot  <= w_p_sat;
        end
        case (i_cmd.op)
            OP_PSQ: begin
                r_psq  <= PSQ_W'((2*VAL_W)'(r_pot) * (2*VAL_W)'(r_pot));
                r_pacc <= '0;
            end
            OP_MUL: begin
                if (r_pp_vld) begin
                    r_pacc <= r_pacc + w_pp_sh;
                end
                r_pp   <= w_pp;
                r_pidx <= i_cmd.idx;
            end
            OP_MACC: begin
                r_pacc <= r_pacc + w_pp_sh;
            end
            OP_DIVI: begin
                r_quo <= r_pacc[P_W-1:2*FRAC_BITS];
                r_rem <= '0;
                r_dvs <= r_cnt;
            end
            OP_DIV: begin
                r_rem <= w_dge ? w_ddiff[CNT_W-1:0] : w_dtrial[CNT_W-1:0];
                r_quo <= {r_quo[Q_W-2:0], w_dge};
            end
            OP_SQI: begin
                r_rad  <= RAD_W'(r_quo);
                r_root <= '0;
                r_srem <= '0;
            end
            OP_SQ: begin
                r_srem <= w_sge ? w_sdiff[SREM_W-1:0] : w_strial[SREM_W-1:0];
                r_root <= {r_root[RT_W-2:0], w_sge};
                r_rad  <= {r_rad[RAD_W-3:0], 2'b00};
            end
            OP_OUT: begin
                r_sens <= (r_root > RT_W'(ONE_VAL)) ? ONE_VAL : VAL_W'(r_root);
            end
            default: begin
            end
        endcase
    end

    assign o_sens = r_sens;

`ifndef ASSERT_OFF
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CNT_W'(MAX_DIMS))
        else $error("element count above limit");
    a_dvs_nz: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.op == OP_DIV) |-> (r_dvs != '0))
        else $error("divide by zero count");
    a_sens_rng: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.op == OP_OUT) |=> (r_sens <= ONE_VAL))
        else $error("result above one");
`endif

endmodule

[hw/rtl/wrd_ctrl.sv]
// ============================================================================
// wrd_ctrl
// Controller: accepts beats, sequences multiply, divide and square-root
// steps after the last beat, and owns the output valid flag.
// ============================================================================
module wrd_ctrl #(
    parameter int MAX_DIMS = wrd_pkg::MAX_DIMS_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    input  logic          i_in_last,
    output logic          o_in_ready,
    input  logic          i_out_ready,
    output logic          o_out_valid,
    output wrd_pkg::t_cmd o_cmd
);
    import wrd_pkg::*;

    localparam int Q_W    = f_q_w(MAX_DIMS);
    localparam int RT_W   = f_rt_w(MAX_DIMS);
    localparam int ITER_W = $clog2(Q_W + 1);

    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_DRAIN = 4'd1;
    localparam logic [3:0] ST_PSQ   = 4'd2;
    localparam logic [3:0] ST_MUL   = 4'd3;
    localparam logic [3:0] ST_MACC  = 4'd4;
    localparam logic [3:0] ST_DIVI  = 4'd5;
    localparam logic [3:0] ST_DIV   = 4'd6;
    localparam logic [3:0] ST_SQI   = 4'd7;
    localparam logic [3:0] ST_SQ    = 4'd8;
    localparam logic [3:0] ST_OUT   = 4'd9;

    logic [3:0]        r_state, n_state;
    logic [ITER_W-1:0] r_cnt, n_cnt;
    logic              r_out_vld, n_out_vld;
    t_cmd              w_cmd;

    always_comb begin
        n_state   = r_state;
        n_cnt     = r_cnt;
        w_cmd.op  = OP_NONE;
        w_cmd.idx = 2'd0;
        n_out_vld = r_out_vld && !i_out_ready;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    w_cmd.op = OP_ACC;
                    if (i_in_last) begin
                        n_state = ST_DRAIN;
                    end
                end
            end
            ST_DRAIN: begin
                n_state = ST_PSQ;
            end
            ST_PSQ: begin
                w_cmd.op = OP_PSQ;
                n_cnt    = '0;
                n_state  = ST_MUL;
            end
            ST_MUL: begin
                w_cmd.op  = OP_MUL;
                w_cmd.idx = r_cnt[1:0];
                n_cnt     = r_cnt + ITER_W'(1);
                if (r_cnt == ITER_W'(MUL_STEPS - 1)) begin
                    n_state = ST_MACC;
                end
            end
            ST_MACC: begin
                w_cmd.op = OP_MACC;
                n_state  = ST_DIVI;
            end
            ST_DIVI: begin
                w_cmd.op = OP_DIVI;
                n_cnt    = '0;
                n_state  = ST_DIV;
            end
            ST_DIV: begin
                w_cmd.op = OP_DIV;
                n_cnt    = r_cnt + ITER_W'(1);
                if (r_cnt == ITER_W'(Q_W - 1)) begin
                    n_state = ST_SQI;
                end
            end
            ST_SQI: begin
                w_cmd.op = OP_SQI;
                n_cnt    = '0;
                n_state  = ST_SQ;
            end
            ST_SQ: begin
                w_cmd.op = OP_SQ;
                n_cnt    = r_cnt + ITER_W'(1);
                if (r_cnt == ITER_W'(RT_W - 1)) begin
                    n_state = ST_OUT;
                end
            end
            ST_OUT: begin
                if (!r_out_vld || i_out_ready) begin
                    w_cmd.op  = OP_OUT;
                    n_out_vld = 1'b1;
                    n_state   = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_cnt     <= '0;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_cnt     <= n_cnt;
            r_out_vld <= n_out_vld;
        end
    end

    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_out_valid = r_out_vld;
    assign o_cmd       = w_cmd;

`ifndef ASSERT_OFF
    a_last_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE && i_in_valid && i_in_last) |=> (r_state == ST_DRAIN))
        else $error("last beat did not start computation");
    a_vld_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_vld) |-> $past(r_state == ST_OUT))
        else $error("output valid raised outside output step");
    a_div_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DIV) |-> (r_cnt < ITER_W'(Q_W)))
        else $error("divide step count overrun");
`endif

endmodule

[hw/rtl/weighted_rms_distance.sv]
// ============================================================================
// weighted_rms_distance
// Potential times sqrt(sum of squared differences / element count), Q1.16,
// rounded down; one result per vector.
// ============================================================================
//  channel  | dir | fields (lsb first)                          | marker
//  s_axis   | in  | condition_value, tolerance_value, potential | tlast = last
//  m_axis   | out | sensitivity                                 | -
//
//  Non-last beats stream into the accumulator back to back.
//  After a last beat is accepted, tready stays low through the drain, potential
//  squared, multiply, multiply-accumulate, divide and square-root steps, which
//  use one-bit-per-cycle restoring divider and square-root loops, and through the
//  output step, where the result is registered and tvalid rises.
//  Reset clears the accumulator, element count, controller and output valid.
//  The result waits in the output register; a full register stalls only the
//  output step of the next vector.
// ============================================================================
module weighted_rms_distance #(
    parameter int MAX_DIMS = wrd_pkg::MAX_DIMS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // condition_value, tolerance_value, potential
    input  logic [wrd_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
    input  logic                              s_axis_tlast,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // sensitivity
    output logic [wrd_pkg::OUT_TDATA_W-1:0]   m_axis_tdata
);
    import wrd_pkg::*;

    t_cmd             w_cmd;
    logic [VAL_W-1:0] w_sens;

    wrd_ctrl #(
        .MAX_DIMS (MAX_DIMS)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .i_in_last   (s_axis_tlast),
        .o_in_ready  (s_axis_tready),
        .i_out_ready (m_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .o_cmd       (w_cmd)
    );

    wrd_dp #(
        .MAX_DIMS (MAX_DIMS)
    ) u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (w_cmd),
        .i_cond  (s_axis_tdata[VAL_W-1:0]),
        .i_tol   (s_axis_tdata[2*VAL_W-1:VAL_W]),
        .i_pot   (s_axis_tdata[3*VAL_W-1:2*VAL_W]),
        .o_sens  (w_sens)
    );

    assign m_axis_tdata = OUT_TDATA_W'(w_sens);

endmodule
